// File: src/multilevel_fcfs_sjf_scheduler_defines.svh
// Assertion macros used by the scheduler datapath.
`ifndef MULTILEVEL_FCFS_SJF_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FCFS_SJF_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MFSS_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("mfss assertion failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MFSS_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("mfss assertion failed");
`else
`define MFSS_ASSERT_IMP(lbl, pre, post)
`define MFSS_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// File: src/mfss_pkg.sv
// Shared types, constants and codes of the multilevel scheduler.
`default_nettype none
package mfss_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int TIME_BITS   = 24;
    localparam int ID_BITS     = 8;
    localparam int BURST_BITS  = 16;
    localparam int STATUS_BITS = 2;
    // completion sum keeps one carry bit above the clock
    localparam int SUM_BITS    = TIME_BITS + 1;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        t_time                 arrival;
        logic [BURST_BITS-1:0] burst;
    } t_job;

    typedef enum logic [0:0] {
        OP_ENQ  = 1'b0,
        OP_DISP = 1'b1
    } t_op;

    typedef enum logic [0:0] {
        LVL_FIFO = 1'b0,
        LVL_SJF  = 1'b1
    } t_level;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_ENQUEUED   = 2'd0,
        STS_DISPATCHED = 2'd1,
        STS_FULL       = 2'd2,
        STS_EMPTY      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SUM,
        S_REPORT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic enq;       // write the input job, report enqueued or full
        logic none;      // report nothing to dispatch
        logic scan_clr;  // start a shortest-burst search
        logic scan_rd;   // read next high-level slot
        logic fifo_rd;   // pop FIFO head
        logic sum;       // take chosen job, compute completion time
        logic report;    // finish timing math, present dispatch result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hi_empty;
        logic fifo_empty;
        logic scan_last;
    } t_stat;

endpackage
`default_nettype wire

// File: src/multilevel_fcfs_sjf_scheduler.sv
// Top level of the two-level (shortest burst over FIFO) job scheduler.
`default_nettype none
// An item is taken on a rising edge with start high and busy low. Every item
// gives exactly one result, shown for one cycle with o_done high; the receiver
// cannot stall it, so it must take it in that cycle. An enqueue, or a dispatch
// with both levels empty, gives its result in the cycle after acceptance and busy
// stays low, so items may follow back to back. A dispatch from the FIFO level
// keeps busy high through the sum and report states, and its result is shown
// from the result registers after the report state. A dispatch from the
// shortest-burst level reads every one of the QUEUE_DEPTH slots through the
// store's single read port, one slot a cycle, keeping busy high through the scan,
// drain, sum and report states. The run clock and completion time saturate.
module multilevel_fcfs_sjf_scheduler (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_operation,
    input  wire logic                               i_level,
    input  wire logic [mfss_pkg::ID_BITS-1:0]       i_job_id,
    input  wire logic [mfss_pkg::TIME_BITS-1:0]     i_arrival,
    input  wire logic [mfss_pkg::BURST_BITS-1:0]    i_burst,
    output logic                                    o_done,
    output logic [mfss_pkg::STATUS_BITS-1:0]        o_status,
    output logic [mfss_pkg::ID_BITS-1:0]            o_granted_id,
    output logic                                    o_granted_level,
    output logic [mfss_pkg::TIME_BITS-1:0]          o_start_time,
    output logic [mfss_pkg::TIME_BITS-1:0]          o_turnaround,
    output logic [mfss_pkg::TIME_BITS-1:0]          o_waiting
);

    mfss_pkg::t_cmd  cmd;
    mfss_pkg::t_stat stat;

    mfss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mfss_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_level         (i_level),
        .i_job_id        (i_job_id),
        .i_arrival       (i_arrival),
        .i_burst         (i_burst),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_id    (o_granted_id),
        .o_granted_level (o_granted_level),
        .o_start_time    (o_start_time),
        .o_turnaround    (o_turnaround),
        .o_waiting       (o_waiting)
    );

endmodule
`default_nettype wire

// File: src/mfss_ctrl.sv
// Controller state machine of the multilevel scheduler.
`default_nettype none
module mfss_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire logic           i_operation,
    input  wire mfss_pkg::t_stat i_stat,
    output mfss_pkg::t_cmd      o_cmd
);

    mfss_pkg::t_state r_state;
    mfss_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            mfss_pkg::S_IDLE: begin
                if (start) begin
                    priority if (i_operation == mfss_pkg::OP_ENQ) begin
                        o_cmd.enq = 1'b1;
                    end else if (!i_stat.hi_empty) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = mfss_pkg::S_SCAN;
                    end else if (!i_stat.fifo_empty) begin
                        // head read lands in time for the sum step
                        o_cmd.fifo_rd = 1'b1;
                        n_state       = mfss_pkg::S_SUM;
                    end else begin
                        o_cmd.none = 1'b1;
                    end
                end
            end
            mfss_pkg::S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = mfss_pkg::S_DRAIN;
                end
            end
            mfss_pkg::S_DRAIN: begin
                // last slot's compare happens here
                n_state = mfss_pkg::S_SUM;
            end
            mfss_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = mfss_pkg::S_REPORT;
            end
            mfss_pkg::S_REPORT: begin
                o_cmd.report = 1'b1;
                n_state      = mfss_pkg::S_IDLE;
            end
            default: begin
                n_state = mfss_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != mfss_pkg::S_IDLE);

endmodule
`default_nettype wire

// File: src/mfss_dpath.sv
// Datapath of the multilevel scheduler: job stores, search, run clock, result registers.
`default_nettype none
`include "multilevel_fcfs_sjf_scheduler_defines.svh"
module mfss_dpath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mfss_pkg::t_cmd                     i_cmd,
    output mfss_pkg::t_stat                         o_stat,
    input  wire logic                               i_level,
    input  wire logic [mfss_pkg::ID_BITS-1:0]       i_job_id,
    input  wire logic [mfss_pkg::TIME_BITS-1:0]     i_arrival,
    input  wire logic [mfss_pkg::BURST_BITS-1:0]    i_burst,
    output logic                                    o_done,
    output logic [mfss_pkg::STATUS_BITS-1:0]        o_status,
    output logic [mfss_pkg::ID_BITS-1:0]            o_granted_id,
    output logic                                    o_granted_level,
    output logic [mfss_pkg::TIME_BITS-1:0]          o_start_time,
    output logic [mfss_pkg::TIME_BITS-1:0]          o_turnaround,
    output logic [mfss_pkg::TIME_BITS-1:0]          o_waiting
);

    localparam int DEPTH = mfss_pkg::QUEUE_DEPTH;
    localparam int IW    = mfss_pkg::IDX_BITS;
    localparam int CW    = mfss_pkg::CNT_BITS;
    localparam int TW    = mfss_pkg::TIME_BITS;

    mfss_pkg::t_job in_job;

    // high level: slot store plus per-slot valid and enqueue rank
    mfss_pkg::t_job  r_hi_mem [DEPTH];
    logic [IW-1:0]   r_hi_rank [DEPTH];
    logic [DEPTH-1:0] r_hi_vld;
    logic [CW-1:0]   r_hi_cnt;
    logic [IW-1:0]   free_idx;
    logic            hi_full;
    logic            hi_wr;
    logic            take;

    // search pipeline
    logic [IW-1:0]   r_scan_idx;
    mfss_pkg::t_job  r_hi_q;
    logic            r_q_vld;
    logic [IW-1:0]   r_q_rank;
    logic [IW-1:0]   r_q_idx;
    logic            r_cmp_pend;
    logic            better;
    mfss_pkg::t_job  r_best;
    logic            r_best_vld;
    logic [IW-1:0]   r_best_rank;
    logic [IW-1:0]   r_best_idx;
    logic            r_src_hi;

    // low level FIFO
    mfss_pkg::t_job  r_fifo_mem [DEPTH];
    mfss_pkg::t_job  r_fifo_q;
    logic [IW-1:0]   r_fifo_head;
    logic [IW-1:0]   r_fifo_tail;
    logic [CW-1:0]   r_fifo_cnt;
    logic            fifo_full;
    logic            fifo_wr;

    // timing
    mfss_pkg::t_time r_clock;
    mfss_pkg::t_time r_fin;
    mfss_pkg::t_time r_arr;
    logic [mfss_pkg::ID_BITS-1:0] r_gid;
    logic            r_glev;
    mfss_pkg::t_job  sel_job;
    logic [mfss_pkg::SUM_BITS-1:0] fin_sum;
    mfss_pkg::t_time turn_val;
    mfss_pkg::t_time wait_val;

    // result registers
    logic                               r_out_stb;
    logic [mfss_pkg::STATUS_BITS-1:0]   r_status;
    logic [mfss_pkg::ID_BITS-1:0]       r_out_id;
    logic                               r_out_lev;
    mfss_pkg::t_time                    r_out_start;
    mfss_pkg::t_time                    r_out_turn;
    mfss_pkg::t_time                    r_out_wait;

    always_comb begin
        in_job.id      = i_job_id;
        in_job.arrival = i_arrival;
        in_job.burst   = i_burst;
    end

    assign hi_full   = (r_hi_cnt == CW'(DEPTH));
    assign fifo_full = (r_fifo_cnt == CW'(DEPTH));
    assign hi_wr     = i_cmd.enq && (i_level == mfss_pkg::LVL_SJF) && !hi_full;
    assign fifo_wr   = i_cmd.enq && (i_level == mfss_pkg::LVL_FIFO) && !fifo_full;
    assign take      = i_cmd.sum && r_src_hi;

    assign o_stat.hi_empty   = (r_hi_cnt == '0);
    assign o_stat.fifo_empty = (r_fifo_cnt == '0);
    assign o_stat.scan_last  = (r_scan_idx == IW'(DEPTH - 1));

    // lowest free high-level slot
    always_comb begin
        free_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (!r_hi_vld[k]) begin
                free_idx = IW'(k);
            end
        end
    end

    // high-level store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (hi_wr) begin
            r_hi_mem[free_idx] <= in_job;
        end
        if (i_cmd.scan_rd) begin
            r_hi_q <= r_hi_mem[r_scan_idx];
        end
    end

    // slot side info is registered alongside the read data
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_q_vld  <= r_hi_vld[r_scan_idx];
            r_q_rank <= r_hi_rank[r_scan_idx];
            r_q_idx  <= r_scan_idx;
        end
    end

    // occupancy of the high level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_vld <= '0;
            r_hi_cnt <= '0;
        end else if (hi_wr) begin
            r_hi_vld[free_idx] <= 1'b1;
            r_hi_cnt           <= r_hi_cnt + CW'(1);
        end else if (take) begin
            r_hi_vld[r_best_idx] <= 1'b0;
            r_hi_cnt             <= r_hi_cnt - CW'(1);
        end
    end

    // enqueue rank: new job goes last, later jobs close the gap on removal
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (hi_wr && (free_idx == IW'(k))) begin
                r_hi_rank[k] <= r_hi_cnt[IW-1:0];
            end else if (take && r_hi_vld[k] && (r_hi_rank[k] > r_best_rank)) begin
                r_hi_rank[k] <= r_hi_rank[k] - IW'(1);
            end
        end
    end

    // search control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_pend <= 1'b0;
            r_best_vld <= 1'b0;
            r_src_hi   <= 1'b0;
        end else begin
            r_cmp_pend <= i_cmd.scan_rd;
            if (i_cmd.scan_clr) begin
                r_scan_idx <= '0;
                r_best_vld <= 1'b0;
                r_src_hi   <= 1'b1;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan_idx <= r_scan_idx + IW'(1);
                end
                if (r_cmp_pend && better) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (i_cmd.fifo_rd) begin
                r_src_hi <= 1'b0;
            end
        end
    end

    // smaller burst wins, equal bursts go to the earlier enqueue
    assign better = r_q_vld && (!r_best_vld || (r_hi_q.burst < r_best.burst) ||
                    ((r_hi_q.burst == r_best.burst) && (r_q_rank < r_best_rank)));

    always_ff @(posedge i_clk) begin
        if (r_cmp_pend && better) begin
            r_best      <= r_hi_q;
            r_best_rank <= r_q_rank;
            r_best_idx  <= r_q_idx;
        end
    end

    // FIFO store
    always_ff @(posedge i_clk) begin
        if (fifo_wr) begin
            r_fifo_mem[r_fifo_tail] <= in_job;
        end
        if (i_cmd.fifo_rd) begin
            r_fifo_q <= r_fifo_mem[r_fifo_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_head <= '0;
            r_fifo_tail <= '0;
            r_fifo_cnt  <= '0;
        end else if (fifo_wr) begin
            r_fifo_tail <= r_fifo_tail + IW'(1);
            r_fifo_cnt  <= r_fifo_cnt + CW'(1);
        end else if (i_cmd.fifo_rd) begin
            r_fifo_head <= r_fifo_head + IW'(1);
            r_fifo_cnt  <= r_fifo_cnt - CW'(1);
        end
    end

    // completion time, saturating at the clock's maximum
    assign sel_job = r_src_hi ? r_best : r_fifo_q;
    assign fin_sum = {1'b0, r_clock} + mfss_pkg::SUM_BITS'(sel_job.burst);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_fin  <= fin_sum[TW] ? '1 : fin_sum[TW-1:0];
            r_arr  <= sel_job.arrival;
            r_gid  <= sel_job.id;
            r_glev <= r_src_hi;
        end
    end

    // differences clamp to zero for jobs that have not arrived yet
    assign turn_val = (r_fin > r_arr) ? (r_fin - r_arr) : '0;
    assign wait_val = (r_clock > r_arr) ? (r_clock - r_arr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
        end else if (i_cmd.report) begin
            r_clock <= r_fin;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_stb <= 1'b0;
        end else begin
            r_out_stb <= i_cmd.enq || i_cmd.none || i_cmd.report;
        end
    end

    // result payload; fields without meaning read zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq || i_cmd.none) begin
            r_out_id    <= '0;
            r_out_lev   <= 1'b0;
            r_out_start <= '0;
            r_out_turn  <= '0;
            r_out_wait  <= '0;
        end
        priority if (i_cmd.enq) begin
            r_status <= ((i_level == mfss_pkg::LVL_SJF) ? hi_full : fifo_full)
                      ? mfss_pkg::STS_FULL : mfss_pkg::STS_ENQUEUED;
        end else if (i_cmd.none) begin
            r_status <= mfss_pkg::STS_EMPTY;
        end else if (i_cmd.report) begin
            r_status    <= mfss_pkg::STS_DISPATCHED;
            r_out_id    <= r_gid;
            r_out_lev   <= r_glev;
            r_out_start <= r_clock;
            r_out_turn  <= turn_val;
            r_out_wait  <= wait_val;
        end else begin
            r_status <= r_status;
        end
    end

    assign o_done          = r_out_stb;
    assign o_status        = r_status;
    assign o_granted_id    = r_out_id;
    assign o_granted_level = r_out_lev;
    assign o_start_time    = r_out_start;
    assign o_turnaround    = r_out_turn;
    assign o_waiting       = r_out_wait;

    // high-level count tracks its valid bits
    `MFSS_ASSERT_IMP(a_hi_cnt_vld, 1'b1, $countones(r_hi_vld) == 32'(r_hi_cnt))
    // FIFO pointers and fill count agree
    `MFSS_ASSERT_IMP(a_fifo_ptrs, 1'b1, (r_fifo_tail - r_fifo_head) == r_fifo_cnt[IW-1:0])
    // a finished high-level search always found a job
    `MFSS_ASSERT_IMP(a_best_found, take, r_best_vld)
    // the report step always shows a dispatched item next cycle
    `MFSS_ASSERT_NXT(a_report_out, i_cmd.report,
        r_out_stb && (r_status == mfss_pkg::STS_DISPATCHED))

endmodule
`default_nettype wire
